// File: design/bilinear_texture_filter_macros.svh
// ----------------------------------------------------------------------------
// Bilinear texture filter assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk and disabled while
// i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_FILTER_MACROS_SVH
`define BILINEAR_TEXTURE_FILTER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BTF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold at the same edge as its antecedent.
`define BTF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/btf_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear texture filter package
// Sizes, field widths, codes and the types passed between the front end, the
// job queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btf_pkg;

    // Image store geometry.
    localparam int unsigned MAX_WIDTH   = 256;
    localparam int unsigned MAX_HEIGHT  = 128;
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned X_W         = $clog2(MAX_WIDTH);
    localparam int unsigned Y_W         = $clog2(MAX_HEIGHT);

    // Field widths.
    localparam int unsigned ADDR_W   = 15;
    localparam int unsigned CH_W     = 16;
    localparam int unsigned TEXEL_W  = 3 * CH_W;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned WIDTH_W  = 9;
    localparam int unsigned HEIGHT_W = 8;

    // Scaled coordinates are Q.16 with the integer part as wide as the size.
    localparam int unsigned SCALED_U_W = COORD_W + WIDTH_W;
    localparam int unsigned SCALED_V_W = COORD_W + HEIGHT_W;

    // Blend arithmetic widths.
    localparam int unsigned LERP_W  = CH_W + FRAC_W;
    localparam int unsigned PROD1_W = CH_W + FRAC_W + 2;
    localparam int unsigned PROD2_W = LERP_W + FRAC_W + 2;

    localparam logic [FRAC_W-1:0] HALF_TEXEL = {1'b1, {(FRAC_W-1){1'b0}}};

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = WIDTH_W;
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 9'd256;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 8'd128;

    // Job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_geom;

    // One classified item: a texel write or the four fetch addresses of a sample.
    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   waddr;
        logic [TEXEL_W-1:0]  wdata;
        logic [ADDR_W-1:0]   a00;
        logic [ADDR_W-1:0]   a10;
        logic [ADDR_W-1:0]   a01;
        logic [ADDR_W-1:0]   a11;
        logic [FRAC_W-1:0]   fu;
        logic [FRAC_W-1:0]   fv;
    } t_job;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } t_queue_status;

endpackage

`default_nettype wire

// File: design/btf_front.sv
// ----------------------------------------------------------------------------
// Bilinear texture filter front end
// Registers accepted beats, scales and splits the coordinates, clamps the
// neighbour indices to the image edge and forms the four texel addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btf_front
    import btf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_advance,
    input  wire t_kind              i_kind,
    input  wire logic [ADDR_W-1:0]  i_texel_address,
    input  wire logic [TEXEL_W-1:0] i_texel,
    input  wire logic [COORD_W-1:0] i_coord_u,
    input  wire logic [COORD_W-1:0] i_coord_v,
    input  wire t_geom              i_geom,
    output logic                    o_push,
    output t_job                    o_job
);

    // Stage 1: accepted beat.
    logic               r_s1_valid;
    t_kind              r_s1_kind;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [TEXEL_W-1:0] r_s1_data;
    logic [COORD_W-1:0] r_s1_u;
    logic [COORD_W-1:0] r_s1_v;

    // Stage 2: scaled coordinates.
    logic                  r_s2_valid;
    t_kind                 r_s2_kind;
    logic [ADDR_W-1:0]     r_s2_addr;
    logic [TEXEL_W-1:0]    r_s2_data;
    logic [SCALED_U_W-1:0] r_s2_su;
    logic [SCALED_V_W-1:0] r_s2_sv;
    logic [SCALED_U_W-1:0] n_s2_su;
    logic [SCALED_V_W-1:0] n_s2_sv;

    // Stage 3: clamped columns, row bases and fractions.
    logic               r_s3_valid;
    t_kind              r_s3_kind;
    logic [ADDR_W-1:0]  r_s3_addr;
    logic [TEXEL_W-1:0] r_s3_data;
    logic [X_W-1:0]     r_s3_x0;
    logic [X_W-1:0]     r_s3_x1;
    logic [ADDR_W-1:0]  r_s3_row0;
    logic [ADDR_W-1:0]  r_s3_row1;
    logic [FRAC_W-1:0]  r_s3_fu;
    logic [FRAC_W-1:0]  r_s3_fv;

    logic [SCALED_U_W-1:0] su_shift;
    logic [SCALED_V_W-1:0] sv_shift;
    logic [WIDTH_W-1:0]    xi;
    logic [HEIGHT_W-1:0]   yi;
    logic [WIDTH_W:0]      xi_next;
    logic [HEIGHT_W:0]     yi_next;
    logic [WIDTH_W-1:0]    w_last;
    logic [HEIGHT_W-1:0]   h_last;
    logic [WIDTH_W-1:0]    x0_clamp;
    logic [WIDTH_W-1:0]    x1_clamp;
    logic [HEIGHT_W-1:0]   y0_clamp;
    logic [HEIGHT_W-1:0]   y1_clamp;
    logic [Y_W+WIDTH_W-1:0] row0_full;
    logic [Y_W+WIDTH_W-1:0] row1_full;
    logic [FRAC_W-1:0]     n_s3_fu;
    logic [FRAC_W-1:0]     n_s3_fv;

    assign n_s2_su = {{WIDTH_W{1'b0}}, r_s1_u} * {{COORD_W{1'b0}}, i_geom.width};
    assign n_s2_sv = {{HEIGHT_W{1'b0}}, r_s1_v} * {{COORD_W{1'b0}}, i_geom.height};

    // A scaled coordinate below half a texel lands on index 0 with no fraction.
    always_comb begin
        su_shift = r_s2_su - {{WIDTH_W{1'b0}}, HALF_TEXEL};
        sv_shift = r_s2_sv - {{HEIGHT_W{1'b0}}, HALF_TEXEL};
        if (r_s2_su < {{WIDTH_W{1'b0}}, HALF_TEXEL}) begin
            xi      = '0;
            n_s3_fu = '0;
        end else begin
            xi      = su_shift[SCALED_U_W-1:FRAC_W];
            n_s3_fu = su_shift[FRAC_W-1:0];
        end
        if (r_s2_sv < {{HEIGHT_W{1'b0}}, HALF_TEXEL}) begin
            yi      = '0;
            n_s3_fv = '0;
        end else begin
            yi      = sv_shift[SCALED_V_W-1:FRAC_W];
            n_s3_fv = sv_shift[FRAC_W-1:0];
        end
    end

    always_comb begin
        w_last  = i_geom.width - WIDTH_W'(1);
        h_last  = i_geom.height - HEIGHT_W'(1);
        xi_next = {1'b0, xi} + (WIDTH_W + 1)'(1);
        yi_next = {1'b0, yi} + (HEIGHT_W + 1)'(1);
        x0_clamp = (xi > w_last) ? w_last : xi;
        x1_clamp = (xi_next > {1'b0, w_last}) ? w_last : xi_next[WIDTH_W-1:0];
        y0_clamp = (yi > h_last) ? h_last : yi;
        y1_clamp = (yi_next > {1'b0, h_last}) ? h_last : yi_next[HEIGHT_W-1:0];
        row0_full = {{WIDTH_W{1'b0}}, y0_clamp[Y_W-1:0]} * {{Y_W{1'b0}}, i_geom.width};
        row1_full = {{WIDTH_W{1'b0}}, y1_clamp[Y_W-1:0]} * {{Y_W{1'b0}}, i_geom.width};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_kind <= i_kind;
            r_s1_addr <= i_texel_address;
            r_s1_data <= i_texel;
            r_s1_u    <= i_coord_u;
            r_s1_v    <= i_coord_v;

            r_s2_kind <= r_s1_kind;
            r_s2_addr <= r_s1_addr;
            r_s2_data <= r_s1_data;
            r_s2_su   <= n_s2_su;
            r_s2_sv   <= n_s2_sv;

            r_s3_kind <= r_s2_kind;
            r_s3_addr <= r_s2_addr;
            r_s3_data <= r_s2_data;
            r_s3_x0   <= x0_clamp[X_W-1:0];
            r_s3_x1   <= x1_clamp[X_W-1:0];
            r_s3_row0 <= row0_full[ADDR_W-1:0];
            r_s3_row1 <= row1_full[ADDR_W-1:0];
            r_s3_fu   <= n_s3_fu;
            r_s3_fv   <= n_s3_fv;
        end
    end

    assign o_push = r_s3_valid && i_advance;

    always_comb begin
        o_job.kind  = r_s3_kind;
        o_job.waddr = r_s3_addr;
        o_job.wdata = r_s3_data;
        o_job.a00   = r_s3_row0 + {{(ADDR_W-X_W){1'b0}}, r_s3_x0};
        o_job.a10   = r_s3_row0 + {{(ADDR_W-X_W){1'b0}}, r_s3_x1};
        o_job.a01   = r_s3_row1 + {{(ADDR_W-X_W){1'b0}}, r_s3_x0};
        o_job.a11   = r_s3_row1 + {{(ADDR_W-X_W){1'b0}}, r_s3_x1};
        o_job.fu    = r_s3_fu;
        o_job.fv    = r_s3_fv;
    end

endmodule

`default_nettype wire

// File: design/btf_queue.sv
// ----------------------------------------------------------------------------
// Bilinear texture filter job queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btf_queue
    import btf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_job      i_job,
    input  wire logic      i_pop,
    output t_job           o_job,
    output t_queue_status  o_status
);

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign n_count = r_count + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

`default_nettype wire

// File: design/btf_back.sv
// ----------------------------------------------------------------------------
// Bilinear texture filter back end
// Texel memory in two copies, each with two read ports, so one beat fetches
// all four neighbours. Followed by a vertical and a horizontal blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btf_back
    import btf_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire t_job           i_job,
    output logic                o_valid,
    output logic [CH_W-1:0]     o_red_out,
    output logic [CH_W-1:0]     o_green_out,
    output logic [CH_W-1:0]     o_blue_out
);

    // Copy 0 serves the upper row of the footprint, copy 1 the lower row.
    logic [TEXEL_W-1:0] r_mem_row0 [STORE_DEPTH];
    logic [TEXEL_W-1:0] r_mem_row1 [STORE_DEPTH];

    logic               w_write;

    logic               r_b1_valid;
    logic [FRAC_W-1:0]  r_b1_fu;
    logic [FRAC_W-1:0]  r_b1_fv;
    logic [TEXEL_W-1:0] r_t00;
    logic [TEXEL_W-1:0] r_t10;
    logic [TEXEL_W-1:0] r_t01;
    logic [TEXEL_W-1:0] r_t11;

    logic               r_b2_valid;
    logic [FRAC_W-1:0]  r_b2_fu;
    logic [LERP_W-1:0]  r_left  [3];
    logic [LERP_W-1:0]  r_right [3];
    logic [LERP_W-1:0]  n_left  [3];
    logic [LERP_W-1:0]  n_right [3];

    logic                      r_b3_valid;
    logic [LERP_W-1:0]         r_b3_left [3];
    logic signed [PROD2_W-1:0] r_b3_prod [3];
    logic signed [PROD2_W-1:0] n_b3_prod [3];

    logic                      r_out_valid;
    logic [CH_W-1:0]           r_out [3];
    logic [CH_W-1:0]           n_out [3];

    assign w_write = i_valid && (i_job.kind == KIND_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem_row0[i_job.waddr] <= i_job.wdata;
        end
        r_t00 <= r_mem_row0[i_job.a00];
        r_t10 <= r_mem_row0[i_job.a10];
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem_row1[i_job.waddr] <= i_job.wdata;
        end
        r_t01 <= r_mem_row1[i_job.a01];
        r_t11 <= r_mem_row1[i_job.a11];
    end

    // Each lerp is written as a*2^16 + f*(b - a), which equals
    // (1-f)*a + f*b exactly and needs one multiplier.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [CH_W-1:0]           t00;
        logic [CH_W-1:0]           t10;
        logic [CH_W-1:0]           t01;
        logic [CH_W-1:0]           t11;
        logic signed [CH_W:0]      diff_l;
        logic signed [CH_W:0]      diff_r;
        logic signed [PROD1_W-1:0] prod_l;
        logic signed [PROD1_W-1:0] prod_r;
        logic signed [PROD1_W-1:0] sum_l;
        logic signed [PROD1_W-1:0] sum_r;
        logic signed [LERP_W:0]    diff_h;
        logic signed [PROD2_W-1:0] sum_h;

        assign t00    = r_t00[CH_W*c +: CH_W];
        assign t10    = r_t10[CH_W*c +: CH_W];
        assign t01    = r_t01[CH_W*c +: CH_W];
        assign t11    = r_t11[CH_W*c +: CH_W];
        assign diff_l = $signed({1'b0, t01}) - $signed({1'b0, t00});
        assign diff_r = $signed({1'b0, t11}) - $signed({1'b0, t10});
        assign prod_l = diff_l * $signed({1'b0, r_b1_fv});
        assign prod_r = diff_r * $signed({1'b0, r_b1_fv});
        assign sum_l  = $signed({2'b00, t00, {FRAC_W{1'b0}}}) + prod_l;
        assign sum_r  = $signed({2'b00, t10, {FRAC_W{1'b0}}}) + prod_r;
        assign n_left[c]  = sum_l[LERP_W-1:0];
        assign n_right[c] = sum_r[LERP_W-1:0];

        assign diff_h       = $signed({1'b0, r_right[c]}) - $signed({1'b0, r_left[c]});
        assign n_b3_prod[c] = diff_h * $signed({1'b0, r_b2_fu});

        assign sum_h    = $signed({2'b00, r_b3_left[c], {FRAC_W{1'b0}}}) + r_b3_prod[c];
        assign n_out[c] = sum_h[CH_W+2*FRAC_W-1:2*FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_b1_valid  <= i_valid && (i_job.kind == KIND_SAMPLE);
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_fu <= i_job.fu;
        r_b1_fv <= i_job.fv;
        r_b2_fu <= r_b1_fu;
        for (int c = 0; c < 3; c++) begin
            r_left[c]    <= n_left[c];
            r_right[c]   <= n_right[c];
            r_b3_left[c] <= r_left[c];
            r_b3_prod[c] <= n_b3_prod[c];
            r_out[c]     <= n_out[c];
        end
    end

    // Texel words hold red in the top channel and blue in the bottom one.
    assign o_valid     = r_out_valid;
    assign o_blue_out  = r_out[0];
    assign o_green_out = r_out[1];
    assign o_red_out   = r_out[2];

endmodule

`default_nettype wire

// File: design/bilinear_texture_filter.sv
// ----------------------------------------------------------------------------
// Bilinear texture filter
// Clamp-to-edge bilinear sampling of an RGB Q8.8 image held in texel memory.
// ----------------------------------------------------------------------------
// A beat is taken whenever start is high and busy is low; with kind low it
// writes one texel, with kind high it requests a filtered sample. The block
// takes one beat per cycle while busy is low. Each sample returns its result
// on o_valid in order; writes return nothing, and a sample taken right after
// a write already sees that texel. The rate is set by the texel memory, kept
// in two copies with two read ports each so the four neighbours of a sample
// are fetched together. Results are not held: the receiver must take each
// one in the cycle it is shown. busy rises only if the job queue between the
// front and back end fills; since the back end drains one job every cycle,
// it stays low in operation. Texel memory is not cleared by reset; write
// every texel in use before sampling. Change image_width or image_height
// only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_texture_filter_macros.svh"

module bilinear_texture_filter
    import btf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_kind,
    input  wire logic [ADDR_W-1:0]     i_texel_address,
    input  wire logic [CH_W-1:0]       i_red_in,
    input  wire logic [CH_W-1:0]       i_green_in,
    input  wire logic [CH_W-1:0]       i_blue_in,
    input  wire logic [COORD_W-1:0]    i_coord_u,
    input  wire logic [COORD_W-1:0]    i_coord_v,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [CH_W-1:0]            o_red_out,
    output logic [CH_W-1:0]            o_green_out,
    output logic [CH_W-1:0]            o_blue_out
);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    t_geom               w_geom;

    logic          w_accept;
    logic          w_advance;
    logic          w_push;
    logic          w_pop;
    t_job          w_push_job;
    t_job          w_pop_job;
    t_queue_status w_q_status;
    logic          w_accept_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one; anything above the store's size acts as that size.
    always_comb begin
        if (r_image_width == '0) begin
            w_geom.width = WIDTH_W'(1);
        end else if (r_image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_geom.width = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_geom.width = r_image_width;
        end
        if (r_image_height == '0) begin
            w_geom.height = HEIGHT_W'(1);
        end else if (r_image_height > HEIGHT_W'(MAX_HEIGHT)) begin
            w_geom.height = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            w_geom.height = r_image_height;
        end
    end

    assign busy            = w_q_status.full;
    assign w_advance       = !w_q_status.full;
    assign w_accept        = start && !busy;
    assign w_pop           = !w_q_status.empty;
    assign w_accept_sample = w_accept && (t_kind'(i_kind) == KIND_SAMPLE);

    btf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_advance       (w_advance),
        .i_kind          (t_kind'(i_kind)),
        .i_texel_address (i_texel_address),
        .i_texel         ({i_red_in, i_green_in, i_blue_in}),
        .i_coord_u       (i_coord_u),
        .i_coord_v       (i_coord_v),
        .i_geom          (w_geom),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    btf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    btf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_pop),
        .i_job       (w_pop_job),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    // The back end drains every cycle, so the queue never holds more than one job.
    `BTF_ASSERT_ALWAYS(a_queue_shallow, w_q_status.count <= QUEUE_CNT_W'(1), "job queue deeper than one")
    `BTF_ASSERT_IMPLY(a_no_overflow, w_push, !w_q_status.full, "push into a full job queue")
    // Three front stages, one queue slot and four back stages.
    `BTF_ASSERT_IMPLY(a_result_latency, o_valid, $past(w_accept_sample, 8), "result without a sample beat")

endmodule

`default_nettype wire
